>>> sv/serial_frame_deframer_core_macros.svh
// Assertion macros used by the deframer top level.
`ifndef SERIAL_FRAME_DEFRAMER_CORE_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sfd_pkg.sv
// Package with the byte codes, header offsets and control types of the deframer.
package sfd_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] OPEN_BYTE = 8'h45;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_7D    = 8'h5D;
    localparam logic [7:0] ESC_7E    = 8'h5E;

    localparam logic [7:0] OFS_NODE = 8'd4;
    localparam logic [7:0] OFS_TYPE = 8'd12;
    localparam logic [7:0] OFS_LEN  = 8'd20;
    localparam logic [7:0] OFS_PAY  = 8'd21;

    localparam logic [5:0] RUN_MAX = 6'd43;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        logic hunt_beat;
        logic frame_beat;
        logic start_run;
        logic load_out;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic open_hit;
        logic end_hit;
        logic out_last;
    } sts_t;

endpackage

>>> sv/sfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/sfd_datapath.sv
// Datapath of the deframer: byte handling, frame store, header capture and result register.
module sfd_datapath
    import sfd_pkg::*;
#(
    parameter int FRAME_MAX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic [7:0] rx_byte,
    output logic [1:0] status,
    output logic [8:0] node_id,
    output logic [7:0] pkt_type,
    output logic [7:0] payload_len,
    output logic       has_byte,
    output logic [7:0] payload_byte,
    output logic [5:0] payload_index,
    output logic       last
);

    localparam int AW = $clog2(FRAME_MAX);
    localparam int FW = $clog2(FRAME_MAX + 1);

    logic [7:0]    prev_byte_reg;
    logic [FW-1:0] fill_count_reg;
    logic [FW-1:0] fill_count_next;
    logic [7:0]    node_b_reg;
    logic [7:0]    type_b_reg;
    logic [7:0]    len_b_reg;
    status_t       run_status_reg;
    status_t       run_status_next;
    logic          run_has_reg;
    logic          run_has_next;
    logic [5:0]    run_cnt_reg;
    logic [5:0]    run_cnt_next;
    logic [5:0]    idx_reg;
    logic [5:0]    idx_inc;

    logic [1:0]    status_reg;
    logic [8:0]    node_id_reg;
    logic [7:0]    pkt_type_reg;
    logic [7:0]    payload_len_reg;
    logic          has_byte_reg;
    logic [7:0]    payload_byte_reg;
    logic [5:0]    payload_index_reg;
    logic          last_reg;

    logic          is_flag;
    logic          prev_esc;
    logic          esc_fix;
    logic          frame_data;
    logic          store_new;
    logic          store_fix;
    logic [FW-1:0] fill_inc;
    logic [FW-1:0] fill_dec;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_addr_ext;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [8:0]    rd_addr_wide;
    logic [7:0]    rd_data;
    logic [9:0]    fill_ext;
    logic [9:0]    need_ext;
    logic          is_short;
    logic          is_too_long;

    assign is_flag    = (rx_byte == FLAG_BYTE);
    assign prev_esc   = (prev_byte_reg == ESC_BYTE);
    assign esc_fix    = (rx_byte == ESC_7D) || (rx_byte == ESC_7E);
    assign frame_data = cmd.frame_beat && !is_flag;
    assign store_new  = frame_data && !prev_esc;
    assign store_fix  = frame_data && prev_esc && (fill_count_reg != '0) && esc_fix;
    assign fill_inc   = fill_count_reg + 1'b1;
    assign fill_dec   = fill_count_reg - 1'b1;

    assign wr_en       = store_new || store_fix;
    assign wr_addr     = store_new ? fill_count_reg[AW-1:0] : fill_dec[AW-1:0];
    assign wr_addr_ext = 8'(wr_addr);
    assign wr_data     = store_new ? rx_byte : ((rx_byte == ESC_7D) ? ESC_BYTE : FLAG_BYTE);

    assign sts.open_hit = (rx_byte == OPEN_BYTE) && (prev_byte_reg == FLAG_BYTE);
    assign sts.end_hit  = is_flag || (store_new && (fill_inc == FW'(FRAME_MAX)));
    assign sts.out_last = last_reg;

    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (cmd.hunt_beat && sts.open_hit)
        begin
            fill_count_next = '0;
        end
        else if (store_new)
        begin
            fill_count_next = fill_inc;
        end
    end

    assign fill_ext    = 10'(fill_count_reg);
    assign need_ext    = 10'(OFS_PAY) + 10'(len_b_reg);
    assign is_short    = (fill_ext < 10'(OFS_PAY));
    assign is_too_long = (need_ext > fill_ext);

    always_comb
    begin
        if (is_short)
        begin
            run_status_next = STATUS_SHORT;
        end
        else if (is_too_long)
        begin
            run_status_next = STATUS_TOO_LONG;
        end
        else
        begin
            run_status_next = STATUS_OK;
        end
        run_has_next = !is_short && !is_too_long && (len_b_reg != 8'd0);
        run_cnt_next = (len_b_reg > 8'(RUN_MAX)) ? RUN_MAX : len_b_reg[5:0];
    end

    assign idx_inc      = idx_reg + 6'd1;
    assign rd_en        = cmd.start_run || cmd.advance;
    assign rd_addr_wide = 9'(OFS_PAY) + 9'(cmd.advance ? idx_inc : 6'd0);

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_wide[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg  <= '0;
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            if (cmd.hunt_beat || frame_data)
            begin
                prev_byte_reg <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr_ext == OFS_NODE))
        begin
            node_b_reg <= wr_data;
        end
        if (wr_en && (wr_addr_ext == OFS_TYPE))
        begin
            type_b_reg <= wr_data;
        end
        if (wr_en && (wr_addr_ext == OFS_LEN))
        begin
            len_b_reg <= wr_data;
        end
        if (cmd.start_run)
        begin
            run_status_reg <= run_status_next;
            run_has_reg    <= run_has_next;
            run_cnt_reg    <= run_cnt_next;
            idx_reg        <= 6'd0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_inc;
        end
        if (cmd.load_out)
        begin
            status_reg        <= run_status_reg;
            node_id_reg       <= (run_status_reg == STATUS_SHORT) ? 9'd0
                                 : ({1'b0, node_b_reg} - 9'd1);
            pkt_type_reg      <= (run_status_reg == STATUS_SHORT) ? 8'd0 : type_b_reg;
            payload_len_reg   <= (run_status_reg == STATUS_SHORT) ? 8'd0 : len_b_reg;
            has_byte_reg      <= run_has_reg;
            payload_byte_reg  <= run_has_reg ? rd_data : 8'd0;
            payload_index_reg <= run_has_reg ? idx_reg : 6'd0;
            last_reg          <= !run_has_reg || (idx_inc == run_cnt_reg);
        end
    end

    assign status        = status_reg;
    assign node_id       = node_id_reg;
    assign pkt_type      = pkt_type_reg;
    assign payload_len   = payload_len_reg;
    assign has_byte      = has_byte_reg;
    assign payload_byte  = payload_byte_reg;
    assign payload_index = payload_index_reg;
    assign last          = last_reg;

endmodule

>>> sv/sfd_ctrl.sv
// Controller state machine of the deframer: hunting, receiving and draining a run.
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_FRAME,
        ST_START,
        ST_LOAD,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   beat;

    assign beat = in_valid && in_ready_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.hunt_beat  = beat && (state_reg == ST_HUNT);
        cmd.frame_beat = beat && (state_reg == ST_FRAME);
        cmd.start_run  = (state_reg == ST_START);
        cmd.load_out   = (state_reg == ST_LOAD);
        cmd.advance    = (state_reg == ST_OUT) && out_ready && !sts.out_last;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT:
            begin
                if (beat && sts.open_hit)
                begin
                    state_next = ST_FRAME;
                end
            end
            ST_FRAME:
            begin
                if (beat && sts.end_hit)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = sts.out_last ? ST_HUNT : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == ST_HUNT) || (state_next == ST_FRAME);
            out_valid_reg <= (state_next == ST_OUT);
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

>>> sv/serial_frame_deframer_core.sv
// Top level of the byte-stuffed serial frame deframer.
// While hunting or receiving a frame, one byte beat is taken every cycle.
// The first result of a frame follows the start and load states after its end beat;
// each further result goes through the load state again and needs one store read.
// Input is held off from the frame end until the last result is taken.
// Asynchronous active-low reset returns to hunting; store contents are not cleared.
`include "serial_frame_deframer_core_macros.svh"

module serial_frame_deframer_core
    import sfd_pkg::*;
#(
    parameter int FRAME_MAX = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status, node_id, pkt_type, payload_len,
                                   // payload_byte, payload_index, zero fill
    output logic        m_tuser,   // has_byte
    output logic        m_tlast
);

    cmd_t       cmd;
    sts_t       sts;
    logic [1:0] status;
    logic [8:0] node_id;
    logic [7:0] pkt_type;
    logic [7:0] payload_len;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;

    sfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sfd_datapath #(
        .FRAME_MAX (FRAME_MAX)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .rx_byte       (s_tdata),
        .status        (status),
        .node_id       (node_id),
        .pkt_type      (pkt_type),
        .payload_len   (payload_len),
        .has_byte      (m_tuser),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .last          (m_tlast)
    );

    assign m_tdata = {7'd0, payload_index, payload_byte, payload_len, pkt_type, node_id, status};

    `SFD_ASSERT_SAME(a_no_overlap, 1'b1, !(s_tready && m_tvalid), "input taken during a run")
    `SFD_ASSERT_SAME(a_empty_single, m_tvalid && !m_tuser, m_tlast, "empty result not last")
    `SFD_ASSERT_NEXT(a_run_gap, m_tvalid && m_tready && !m_tlast, !m_tvalid, "no read gap")
    `SFD_ASSERT_NEXT(a_run_end, m_tvalid && m_tready && m_tlast, s_tready, "no return to hunt")

endmodule
